/* hw/rtl/lpcd_pkg.sv */
// ----------------------------------------------------------------------------
// lpcd_pkg
// Shared constants, types and register codes of the LRU page cache directory.
// ----------------------------------------------------------------------------
package lpcd_pkg;

  // Directory geometry
  localparam int unsigned Slots     = 16;
  localparam int unsigned PageBits  = 32;
  localparam int unsigned SlotW     = $clog2(Slots);
  localparam int unsigned SizeW     = PageBits + 1;
  localparam int unsigned GrowPages = 8;

  // Port field widths
  localparam int unsigned PageNumW   = 32;
  localparam int unsigned SlotIdxW   = 4;
  localparam int unsigned EvPageW    = 32;
  localparam int unsigned FilePagesW = 33;

  // Configuration port
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgIdxW  = CfgAddrW - 2;

  localparam logic [CfgIdxW-1:0]  RegInitialFilePages = CfgIdxW'(0);
  localparam logic [CfgDataW-1:0] ResetFilePages      = CfgDataW'(8);

  typedef logic [PageBits-1:0] page_t;
  typedef logic [SlotW-1:0]    slot_t;
  typedef logic [SizeW-1:0]    size_t;

  // Lookup result handed from the directory to the result stage
  typedef struct packed {
    logic  hit;
    slot_t slot;
    logic  ev_valid;
    page_t ev_page;
  } lookup_t;

endpackage

/* hw/rtl/lpcd_if.sv */
// ----------------------------------------------------------------------------
// lpcd_req_if / lpcd_rsp_if
// Valid/ready channels for requests and results of the page cache directory.
// ----------------------------------------------------------------------------
interface lpcd_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lpcd_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [3:0]  slot_index;
  logic        evicted_valid;
  logic [31:0] evicted_page;
  logic        file_extended;
  logic [32:0] file_pages;

  modport source (output valid, output hit, output slot_index, output evicted_valid,
                  output evicted_page, output file_extended, output file_pages,
                  input ready);
  modport sink   (input valid, input hit, input slot_index, input evicted_valid,
                  input evicted_page, input file_extended, input file_pages,
                  output ready);
endinterface

/* hw/rtl/lpcd_dir.sv */
// ----------------------------------------------------------------------------
// lpcd_dir
// Slot tags, valid bits and recency ranks; parallel lookup and LRU update.
// ----------------------------------------------------------------------------
module lpcd_dir import lpcd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  page_t   page_i,
  input  logic    update_i,
  output lookup_t lookup_o
);

  page_t             slot_page_q [Slots];
  logic [Slots-1:0]  slot_valid_q;
  slot_t             rank_q [Slots];
  slot_t             rank_d [Slots];

  logic [Slots-1:0]  hit_vec;
  logic [Slots-1:0]  lru_vec;
  slot_t             hit_idx;
  slot_t             lru_idx;
  logic              hit;
  slot_t             sel;
  slot_t             sel_rank;
  logic              ev_valid;

  // Tag compare and LRU detect, one lane per slot
  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      hit_vec[i] = slot_valid_q[i] && (slot_page_q[i] == page_i);
      lru_vec[i] = (rank_q[i] == '0);
    end
  end

  // Lowest matching slot wins
  always_comb begin
    hit_idx = '0;
    lru_idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = SlotW'(i);
      end
      if (lru_vec[i]) begin
        lru_idx = SlotW'(i);
      end
    end
  end

  assign hit      = |hit_vec;
  assign sel      = hit ? hit_idx : lru_idx;
  assign sel_rank = rank_q[sel];
  assign ev_valid = !hit && slot_valid_q[sel];

  assign lookup_o.hit      = hit;
  assign lookup_o.slot     = sel;
  assign lookup_o.ev_valid = ev_valid;
  assign lookup_o.ev_page  = ev_valid ? slot_page_q[sel] : '0;

  // Selected slot goes to the top; ranks above it slide down
  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      if (sel == SlotW'(i)) begin
        rank_d[i] = SlotW'(Slots - 1);
      end else if (rank_q[i] > sel_rank) begin
        rank_d[i] = rank_q[i] - SlotW'(1);
      end else begin
        rank_d[i] = rank_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      for (int i = 0; i < Slots; i++) begin
        rank_q[i] <= SlotW'(i);
      end
    end else if (update_i) begin
      slot_valid_q[sel] <= 1'b1;
      for (int i = 0; i < Slots; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // Tags: written on a miss, read only while valid
  always_ff @(posedge clk_i) begin
    if (update_i && !hit) begin
      slot_page_q[sel] <= page_i;
    end
  end

endmodule

/* hw/rtl/lru_page_cache_directory_core.sv */
// ----------------------------------------------------------------------------
// lru_page_cache_directory_core
// Fully associative page cache directory with LRU replacement and file size
// tracking.
// ----------------------------------------------------------------------------
// Usage:
//   req : one page number per transfer (valid/ready).
//   rsp : one result per request, in order: hit flag, slot now holding the
//         page, evicted page (if a valid one was displaced), file growth flag
//         and file size after the request.
//   APB : register 0 at byte address 0 is initial_file_pages; a write also
//         loads the tracked file size. pready is tied high. Write only when
//         no request is in flight.
// Flow: a request transfer lands in the input register; once it advances, the
//   tag compare, LRU pick and rank update run and the result is registered.
// Throughput: one request per cycle when rsp is not held; the 16-lane compare
//   and rank update are a single combinational pass between the input and
//   result registers.
// Reset: all slots empty, slot 0 least recent, last slot most recent, file
//   size 8 pages; no transfer is pending on either channel.
// Stall: while rsp is held, the result register keeps its transfer and the
//   input register holds one more request; then req.ready drops.
// ----------------------------------------------------------------------------
module lru_page_cache_directory_core import lpcd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  lpcd_req_if.sink            req,
  lpcd_rsp_if.source          rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  // Input register
  logic          req_vld_q;
  page_t         req_page_q;
  logic          advance;

  // Result register
  logic          rsp_vld_q, rsp_vld_d;
  logic          hit_q;
  slot_t         slot_q;
  logic          ev_valid_q;
  page_t         ev_page_q;
  logic          ext_q;
  size_t         file_pages_q;

  // File size tracking and configuration
  logic [CfgDataW-1:0] init_pages_q;
  size_t               size_q, size_d;
  logic                cfg_wr;
  logic                ext;
  size_t               grown;

  lookup_t       lookup;

  // --------------------------------------------------------------------------
  // Handshake: the input stage drains whenever the result register is free
  // or being taken in this cycle.
  // --------------------------------------------------------------------------
  assign advance   = req_vld_q && (!rsp_vld_q || rsp.ready);
  assign req.ready = !req_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (req.ready) begin
      req_vld_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      req_page_q <= PageBits'(req.page_number);
    end
  end

  // --------------------------------------------------------------------------
  // Directory: lookup of the held request, state update on advance
  // --------------------------------------------------------------------------
  lpcd_dir u_dir (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .page_i   (req_page_q),
    .update_i (advance),
    .lookup_o (lookup)
  );

  // --------------------------------------------------------------------------
  // File size: grows to page+8 on a miss at or past end of file.
  // --------------------------------------------------------------------------
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[CfgAddrW-1:2] == RegInitialFilePages);
  assign grown  = SizeW'(req_page_q) + SizeW'(GrowPages);
  assign ext    = !lookup.hit && (SizeW'(req_page_q) >= size_q);

  always_comb begin
    size_d = size_q;
    if (cfg_wr) begin
      size_d = SizeW'(pwdata);
    end else if (advance && ext) begin
      size_d = grown;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_pages_q <= ResetFilePages;
      size_q       <= SizeW'(ResetFilePages);
    end else begin
      size_q <= size_d;
      if (cfg_wr) begin
        init_pages_q <= pwdata;
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[CfgAddrW-1:2] == RegInitialFilePages) ? init_pages_q : '0;

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_comb begin
    rsp_vld_d = rsp_vld_q;
    if (advance) begin
      rsp_vld_d = 1'b1;
    end else if (rsp.ready) begin
      rsp_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else begin
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hit_q        <= lookup.hit;
      slot_q       <= lookup.slot;
      ev_valid_q   <= lookup.ev_valid;
      ev_page_q    <= lookup.ev_page;
      ext_q        <= ext;
      file_pages_q <= ext ? grown : size_q;
    end
  end

  assign rsp.valid         = rsp_vld_q;
  assign rsp.hit           = hit_q;
  assign rsp.slot_index    = SlotIdxW'(slot_q);
  assign rsp.evicted_valid = ev_valid_q;
  assign rsp.evicted_page  = EvPageW'(ev_page_q);
  assign rsp.file_extended = ext_q;
  assign rsp.file_pages    = FilePagesW'(file_pages_q);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A hit neither evicts nor grows the file
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q && hit_q |-> !ev_valid_q && !ext_q)
    else $error("hit result carries eviction or growth");

  // File size only shrinks through a configuration write
  a_size_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_wr |=> size_q >= $past(size_q))
    else $error("file size decreased without a config write");

  // Both stages full and the result stalled: no new request may be taken
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_vld_q && rsp_vld_q && !rsp.ready |-> !req.ready)
    else $error("request taken while pipeline is full");

  // A held result must not be overwritten
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q && !rsp.ready |=> rsp_vld_q && $stable(file_pages_q) && $stable(slot_q))
    else $error("stalled result changed");

endmodule

/* tb/lpcd_directory_checker.sv */
// ----------------------------------------------------------------------------
// lpcd_directory_checker
// Watches the request, result and register channels of the page cache
// directory. It keeps its own copy of the slots, the LRU ranks and the file
// size, works out the result of each request transfer and compares the
// result transfers against those results in order.
// ----------------------------------------------------------------------------
module lpcd_directory_checker import lpcd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  lpcd_req_if                 req,
  lpcd_rsp_if                 rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  input  logic [CfgDataW-1:0] prdata,
  input  logic                pready,
  output int unsigned         mismatches_o,
  output int unsigned         outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  hit;
    logic [SlotIdxW-1:0]   slot;
    logic                  ev_valid;
    logic [EvPageW-1:0]    ev_page;
    logic                  extended;
    logic [FilePagesW-1:0] file_pages;
  } dir_result_t;

  page_t               slot_page  [Slots];
  logic                slot_valid [Slots];
  slot_t               slot_rank  [Slots];
  size_t               file_size;
  logic [CfgDataW-1:0] initial_pages;

  dir_result_t due_results[$];
  int unsigned mismatch_cnt;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: result %s: got %0h, want %0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Look up one page, update slots, ranks and file size, return the result.
  function automatic dir_result_t access_page(input logic [PageNumW-1:0] page_in);
    page_t       pg;
    slot_t       sel;
    slot_t       old_rank;
    logic        found;
    dir_result_t res;
    pg    = page_in[PageBits-1:0];
    sel   = '0;
    found = 1'b0;
    res   = '0;
    for (int i = 0; i < Slots; i++) begin
      if (!found && slot_valid[i] && slot_page[i] == pg) begin
        found = 1'b1;
        sel   = slot_t'(i);
      end
    end
    if (!found) begin
      for (int i = Slots - 1; i >= 0; i--) begin
        if (slot_rank[i] == '0) sel = slot_t'(i);
      end
      if (slot_valid[sel]) begin
        res.ev_valid = 1'b1;
        res.ev_page  = EvPageW'(slot_page[sel]);
      end
      slot_page[sel]  = pg;
      slot_valid[sel] = 1'b1;
      // growth only on a miss at or past the end of the file
      if (size_t'(pg) + size_t'(1) > file_size) begin
        file_size    = size_t'(pg) + size_t'(GrowPages);
        res.extended = 1'b1;
      end
    end
    old_rank = slot_rank[sel];
    for (int i = 0; i < Slots; i++) begin
      if (slot_rank[i] > old_rank) slot_rank[i] = slot_rank[i] - slot_t'(1);
    end
    slot_rank[sel]  = slot_t'(Slots - 1);
    res.hit        = found;
    res.slot       = SlotIdxW'(sel);
    res.file_pages = FilePagesW'(file_size);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dir_result_t         want;
    logic [CfgDataW-1:0] want_rd;
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        slot_page[i]  = '0;
        slot_valid[i] = 1'b0;
        slot_rank[i]  = slot_t'(i);
      end
      initial_pages = ResetFilePages;
      file_size     = size_t'(ResetFilePages);
      due_results.delete();
      mismatch_cnt  = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("with no request pending", 64'(rsp.slot_index), 64'h0);
        end else begin
          want = due_results.pop_front();
          if (rsp.hit !== want.hit)
            report_mismatch("hit", 64'(rsp.hit), 64'(want.hit));
          if (rsp.slot_index !== want.slot)
            report_mismatch("slot_index", 64'(rsp.slot_index), 64'(want.slot));
          if (rsp.evicted_valid !== want.ev_valid)
            report_mismatch("evicted_valid", 64'(rsp.evicted_valid), 64'(want.ev_valid));
          if (rsp.evicted_page !== want.ev_page)
            report_mismatch("evicted_page", 64'(rsp.evicted_page), 64'(want.ev_page));
          if (rsp.file_extended !== want.extended)
            report_mismatch("file_extended", 64'(rsp.file_extended), 64'(want.extended));
          if (rsp.file_pages !== want.file_pages)
            report_mismatch("file_pages", 64'(rsp.file_pages), 64'(want.file_pages));
        end
      end
      if (req.valid && req.ready) begin
        due_results.push_back(access_page(req.page_number));
      end
      // register read: the start size, or zero where no register lies
      if (psel && penable && !pwrite && pready) begin
        want_rd = (paddr[CfgAddrW-1:2] == RegInitialFilePages) ? initial_pages : '0;
        if (prdata !== want_rd)
          report_mismatch("prdata", 64'(prdata), 64'(want_rd));
      end
      // register write: loads the start size and the tracked size alike
      if (psel && penable && pwrite && pready &&
          paddr[CfgAddrW-1:2] == RegInitialFilePages) begin
        initial_pages = pwdata;
        file_size     = size_t'(pwdata);
      end
      mismatches_o  <= mismatch_cnt;
      outstanding_o <= due_results.size();
    end
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Top of the page cache directory testbench. Drives requests, register
// writes and result backpressure, runs directed and random phases under
// several idling mixes, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb;
  import lpcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PhaseCount  = 5;
  localparam int unsigned PhaseItems  = 326;
  localparam int unsigned HoldCycles  = 300;    // long receiver hold-off
  localparam int unsigned QuietLimit  = 3000;   // cycles with no transfer at all
  localparam int unsigned SettleWait  = 4;      // settle wait after the last result
  localparam int unsigned HotMax      = 32;

  localparam logic [CfgAddrW-1:0] InitPagesAddr = {RegInitialFilePages, 2'b00};
  // first address past the register list; writes there must be dropped
  localparam logic [CfgAddrW-1:0] UnusedRegAddr = {~RegInitialFilePages, 2'b00};

  // sender idle / receiver stall percentages per phase
  localparam int PhaseIdle  [PhaseCount] = '{0, 61, 0, 20, 0};
  localparam int PhaseStall [PhaseCount] = '{0, 0, 61, 20, 0};

  // opening pages: zero, the file-end boundary, all-ones, bit patterns
  localparam logic [31:0] Opening [10] = '{
    32'h0000_0000, 32'h0000_0007, 32'h0000_0008, 32'h0000_0000,
    32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA,
    32'h8000_0000, 32'h0000_0001
  };

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  int          send_idle_pct;
  int          stall_pct;
  int unsigned hold_reqs;     // bumped by stimulus; the receiver counts the hold
  int unsigned mismatches;
  int unsigned outstanding;

  page_t       hot_pages [HotMax];
  int unsigned hot_n;

  lpcd_req_if req_ch ();
  lpcd_rsp_if rsp_ch ();

  lru_page_cache_directory_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lpcd_directory_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  // The hold is counted here so the sender keeps offering meanwhile and the
  // core fills both registers and drops req.ready.
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (hold_reqs != hold_seen) begin
        hold_seen++;
        hold_left = HoldCycles - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("end of test: mismatches");
    $finish;
  end

  // One request transfer, after a random number of idle cycles. valid stays
  // high on return so back-to-back transfers need no extra edge.
  task automatic send_page(input logic [31:0] pg);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.page_number <= pg;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Stop offering and wait until every result has come back, then let the
  // pipeline settle. The first edge lets the checker record the last transfer.
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the write lands at the edge with pready.
  task automatic write_reg(input logic [CfgAddrW-1:0] addr,
                           input logic [CfgDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read transfer; the checker compares prdata at the access edge.
  task automatic read_reg(input logic [CfgAddrW-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Working set for a phase: sometimes fits in the 16 slots, sometimes not,
  // mixing pages near the file end with pages anywhere.
  task automatic fill_hot_set();
    hot_n = $urandom_range(10, HotMax);
    for (int i = 0; i < HotMax; i++) begin
      hot_pages[i] = ($urandom_range(1) == 0) ? page_t'($urandom_range(48)) : $urandom();
    end
  endtask

  function automatic logic [31:0] pick_page();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return hot_pages[$urandom_range(hot_n - 1)];
    if (roll < 78) return 32'($urandom_range(63));
    if (roll < 92) return $urandom();
    if (roll < 96) return 32'hFFFF_FFFF - 32'($urandom_range(3));
    return 32'($urandom_range(3));
  endfunction

  function automatic logic [CfgDataW-1:0] phase_file_pages(input int p);
    case (p)
      0:       return ResetFilePages;
      1:       return '0;
      2:       return '1;
      3:       return CfgDataW'($urandom_range(64));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.page_number <= '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_reqs     = 0;
    hot_n         = 1;
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, back to back with an always-ready receiver.
    // Opening pages: boundary at the file end (7 stays, 8 grows), a hit,
    // all-ones page growing the size into bit 32, alternating bit patterns.
    foreach (Opening[i]) send_page(Opening[i]);
    // fill every slot and push two evictions of the least recent pages
    for (int i = 0; i < 9; i++) send_page(32'(100 + i));
    send_page(32'hFFFF_FFFF);  // hit on a long-cached page
    drain();

    // shrink the file to nothing: a hit past the end must not grow it,
    // a miss past the end must
    write_reg(InitPagesAddr, '0);
    read_reg(InitPagesAddr);
    send_page(32'h5555_5555);
    send_page(32'h0000_0003);
    drain();
    // write to an address with no register behind it: no effect
    write_reg(UnusedRegAddr, '0);
    read_reg(UnusedRegAddr);
    send_page(32'h0000_000B);
    drain();
    // largest start size: only the all-ones page can lie past the end
    write_reg(InitPagesAddr, '1);
    send_page(32'hFFFF_FFFD);
    send_page(32'h0000_0000);

    // Random phases, each under the idling mix and start size set for it.
    for (int p = 0; p < PhaseCount; p++) begin
      drain();
      write_reg(InitPagesAddr, phase_file_pages(p));
      read_reg(InitPagesAddr);
      send_idle_pct = PhaseIdle[p];
      stall_pct     = PhaseStall[p];
      fill_hot_set();
      for (int n = 0; n < PhaseItems; n++) begin
        // receiver hold-off with the sender still pushing
        if (p == 0 && n == PhaseItems / 2) hold_reqs++;
        // sender pause until the directory has answered everything
        if (p == 2 && n == PhaseItems / 2) drain();
        // new working set now and then so hits and thrashing both occur
        if (n % 100 == 99) fill_hot_set();
        send_page(pick_page());
      end
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* lru_page_cache_directory_core.f */
hw/rtl/lpcd_pkg.sv
hw/rtl/lpcd_if.sv
hw/rtl/lpcd_dir.sv
hw/rtl/lru_page_cache_directory_core.sv
tb/lpcd_directory_checker.sv
tb/tb.sv
